### src/tes_pkg.sv
// ----------------------------------------------------------------------------
// tes_pkg
// Shared types, constants and helpers of the tone effect sequencer.
// ----------------------------------------------------------------------------
package tes_pkg;

    localparam int DEFAULT_NOTE_DEPTH = 64;

    localparam int ACTION_W    = 2;
    localparam int LOC_W       = 6;
    localparam int LOC_RANGE   = 64;
    localparam int WORD_W      = 32;
    localparam int HALF_W      = 16;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 24;
    localparam int RES_W       = 18;

    localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_START = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd2;

    typedef struct packed {
        logic              playing;
        logic [HALF_W-1:0] tone_divider;
        logic              tone_enable;
    } result_t;

    // a word below 0x10000 closes an effect and carries its repeat count
    function automatic logic is_end_marker(input logic [WORD_W-1:0] word);
        return (word[WORD_W-1:HALF_W] == '0);
    endfunction

endpackage

### src/tes_note_mem.sv
// ----------------------------------------------------------------------------
// tes_note_mem
// Note word memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tes_note_mem #(
    parameter int NOTE_DEPTH = tes_pkg::DEFAULT_NOTE_DEPTH
) (
    input  logic                          aclk,
    input  logic                          wr_en,
    input  logic [$clog2(NOTE_DEPTH)-1:0] wr_addr,
    input  logic [tes_pkg::WORD_W-1:0]    wr_data,
    input  logic [$clog2(NOTE_DEPTH)-1:0] rd_addr,
    output logic [tes_pkg::WORD_W-1:0]    rd_data
);

    logic [tes_pkg::WORD_W-1:0] mem [NOTE_DEPTH];
    logic [tes_pkg::WORD_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### src/tes_ctrl.sv
// ----------------------------------------------------------------------------
// tes_ctrl
// Playback sequencer: takes items, walks the note memory, keeps play state.
// ----------------------------------------------------------------------------
module tes_ctrl #(
    parameter int NOTE_DEPTH = tes_pkg::DEFAULT_NOTE_DEPTH
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [tes_pkg::ACTION_W-1:0]     in_action,
    input  logic [tes_pkg::LOC_W-1:0]        in_location,
    input  logic [tes_pkg::WORD_W-1:0]       in_word,
    output logic                             mem_wr_en,
    output logic [$clog2(NOTE_DEPTH)-1:0]    mem_wr_addr,
    output logic [tes_pkg::WORD_W-1:0]       mem_wr_data,
    output logic [$clog2(NOTE_DEPTH)-1:0]    mem_rd_addr,
    input  logic [tes_pkg::WORD_W-1:0]       mem_rd_data,
    input  logic                             res_free,
    output logic                             res_push,
    output tes_pkg::result_t                 res
);

    localparam int AW = $clog2(NOTE_DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(NOTE_DEPTH - 1);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_EXEC = 6'b000010,
        ST_ADV  = 6'b000100,
        ST_LOAD = 6'b001000,
        ST_SCAN = 6'b010000,
        ST_FIN  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [tes_pkg::ACTION_W-1:0] action_reg, action_next;
    logic [AW-1:0] loc_reg, loc_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [AW-1:0] start_reg, start_next;
    logic [AW-1:0] scan_addr_reg, scan_addr_next;
    logic [AW-1:0] scan_cnt_reg, scan_cnt_next;
    logic [tes_pkg::HALF_W-1:0] ticks_reg, ticks_next;
    logic [tes_pkg::HALF_W-1:0] reps_reg, reps_next;
    logic [tes_pkg::HALF_W-1:0] div_reg, div_next;
    logic stopped_reg, stopped_next;
    logic tone_reg, tone_next;

    logic [AW-1:0] loc_mod_tab [tes_pkg::LOC_RANGE];
    logic [AW-1:0] loc_in;
    logic [AW-1:0] pos_inc;
    logic [tes_pkg::HALF_W-1:0] ticks_dec;
    logic [tes_pkg::HALF_W-1:0] reps_dec;
    logic in_fire;

    function automatic logic [AW-1:0] next_addr(input logic [AW-1:0] a);
        return (a == LAST_ADDR) ? '0 : a + AW'(1);
    endfunction

    // location folded into the note memory range
    for (genvar g = 0; g < tes_pkg::LOC_RANGE; g++) begin : g_loc_mod
        assign loc_mod_tab[g] = AW'(g % NOTE_DEPTH);
    end

    assign loc_in    = loc_mod_tab[in_location];
    assign pos_inc   = next_addr(pos_reg);
    assign ticks_dec = ticks_reg - 16'd1;
    assign reps_dec  = reps_reg - 16'd1;

    assign in_ready    = (state_reg == ST_IDLE);
    assign in_fire     = in_valid && in_ready;
    assign mem_wr_en   = in_fire && (in_action == tes_pkg::ACT_WRITE);
    assign mem_wr_addr = loc_in;
    assign mem_wr_data = in_word;

    assign res.tone_enable  = tone_reg;
    assign res.tone_divider = div_reg;
    assign res.playing      = !stopped_reg;

    always_comb begin
        state_next     = state_reg;
        action_next    = action_reg;
        loc_next       = loc_reg;
        pos_next       = pos_reg;
        start_next     = start_reg;
        scan_addr_next = scan_addr_reg;
        scan_cnt_next  = scan_cnt_reg;
        ticks_next     = ticks_reg;
        reps_next      = reps_reg;
        div_next       = div_reg;
        stopped_next   = stopped_reg;
        tone_next      = tone_reg;
        mem_rd_addr    = pos_reg;
        res_push       = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    action_next = in_action;
                    loc_next    = loc_in;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                unique case (action_reg)
                    tes_pkg::ACT_TICK: begin
                        if (stopped_reg) begin
                            state_next = ST_FIN;
                        end else begin
                            ticks_next = ticks_dec;
                            if (ticks_dec != '0) begin
                                state_next = ST_FIN;
                            end else begin
                                pos_next    = pos_inc;
                                mem_rd_addr = pos_inc;
                                state_next  = ST_ADV;
                            end
                        end
                    end
                    tes_pkg::ACT_START: begin
                        pos_next       = loc_reg;
                        start_next     = loc_reg;
                        stopped_next   = 1'b0;
                        reps_next      = 16'd1;
                        mem_rd_addr    = loc_reg;
                        scan_addr_next = next_addr(loc_reg);
                        scan_cnt_next  = '0;
                        state_next     = ST_SCAN;
                    end
                    default: begin
                        state_next = ST_FIN;
                    end
                endcase
            end
            ST_ADV: begin
                if (tes_pkg::is_end_marker(mem_rd_data)) begin
                    reps_next = reps_dec;
                    if (reps_dec == '0) begin
                        tone_next    = 1'b0;
                        stopped_next = 1'b1;
                        state_next   = ST_FIN;
                    end else begin
                        pos_next    = start_reg;
                        mem_rd_addr = start_reg;
                        state_next  = ST_LOAD;
                    end
                end else begin
                    ticks_next = mem_rd_data[tes_pkg::WORD_W-1:tes_pkg::HALF_W];
                    div_next   = mem_rd_data[tes_pkg::HALF_W-1:0];
                    tone_next  = 1'b1;
                    state_next = ST_FIN;
                end
            end
            ST_LOAD: begin
                ticks_next = mem_rd_data[tes_pkg::WORD_W-1:tes_pkg::HALF_W];
                div_next   = mem_rd_data[tes_pkg::HALF_W-1:0];
                tone_next  = 1'b1;
                state_next = ST_FIN;
            end
            ST_SCAN: begin
                // first word of the effect is also the note that plays
                if (scan_cnt_reg == '0) begin
                    ticks_next = mem_rd_data[tes_pkg::WORD_W-1:tes_pkg::HALF_W];
                    div_next   = mem_rd_data[tes_pkg::HALF_W-1:0];
                    tone_next  = 1'b1;
                end
                if (tes_pkg::is_end_marker(mem_rd_data)) begin
                    reps_next  = mem_rd_data[tes_pkg::HALF_W-1:0];
                    state_next = ST_FIN;
                end else if (scan_cnt_reg == LAST_ADDR) begin
                    state_next = ST_FIN;
                end else begin
                    mem_rd_addr    = scan_addr_reg;
                    scan_addr_next = next_addr(scan_addr_reg);
                    scan_cnt_next  = scan_cnt_reg + AW'(1);
                end
            end
            ST_FIN: begin
                if (res_free) begin
                    res_push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pos_reg     <= '0;
            start_reg   <= '0;
            ticks_reg   <= '0;
            reps_reg    <= '0;
            div_reg     <= '0;
            stopped_reg <= 1'b1;
            tone_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            start_reg   <= start_next;
            ticks_reg   <= ticks_next;
            reps_reg    <= reps_next;
            div_reg     <= div_next;
            stopped_reg <= stopped_next;
            tone_reg    <= tone_next;
        end
    end

    always_ff @(posedge aclk) begin
        action_reg    <= action_next;
        loc_reg       <= loc_next;
        scan_addr_reg <= scan_addr_next;
        scan_cnt_reg  <= scan_cnt_next;
    end

`ifndef NO_ASSERTIONS
    a_stop_silences: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(stopped_reg) |-> !tone_reg)
        else $error("effect stopped with the tone still on");

    a_walk_only_playing: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ADV || state_reg == ST_LOAD || state_reg == ST_SCAN)
        |-> !stopped_reg)
        else $error("note memory walk while stopped");

    a_write_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_wr_en |-> (state_reg == ST_IDLE))
        else $error("note write outside idle");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && state_next == ST_SCAN) |=>
        (scan_cnt_reg == $past(scan_cnt_reg) + AW'(1)))
        else $error("marker scan count skipped");
`endif

endmodule

### src/tes_out_reg.sv
// ----------------------------------------------------------------------------
// tes_out_reg
// Result register towards the master side, packs the result item.
// ----------------------------------------------------------------------------
module tes_out_reg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            push,
    input  tes_pkg::result_t                res,
    output logic                            free,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tes_pkg::M_TDATA_W-1:0]   m_tdata
);

    logic             valid_reg;
    tes_pkg::result_t data_reg;

    assign free     = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(tes_pkg::M_TDATA_W - tes_pkg::RES_W){1'b0}},
                       data_reg.playing, data_reg.tone_divider, data_reg.tone_enable};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (push) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            data_reg <= res;
        end
    end

endmodule

### src/tone_effect_sequencer_top.sv
// ----------------------------------------------------------------------------
// tone_effect_sequencer_top
// Sound-effect player over a note memory, stream interface on both sides.
// ----------------------------------------------------------------------------
// Every input item gives one result item with the tone state after it. A write
// item, an unused action or a tick within a note passes through the execute and
// finish states; a tick that ends a note also passes the advance state, and the
// load state when the effect restarts. A start item scans for the end marker, up to
// NOTE_DEPTH words, since the single read port of the note memory steps one
// word a cycle. The next item is taken once the previous result sits in the
// output register.
module tone_effect_sequencer_top #(
    parameter int NOTE_DEPTH = tes_pkg::DEFAULT_NOTE_DEPTH
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [tes_pkg::S_TDATA_W-1:0]      s_tdata,  // location, note_word
    input  logic [tes_pkg::ACTION_W-1:0]       s_tuser,  // action
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [tes_pkg::M_TDATA_W-1:0]      m_tdata   // tone_enable, tone_divider, playing
);

    localparam int AW = $clog2(NOTE_DEPTH);

    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic [tes_pkg::WORD_W-1:0] wr_data;
    logic [AW-1:0]              rd_addr;
    logic [tes_pkg::WORD_W-1:0] rd_data;
    logic                       res_free;
    logic                       res_push;
    tes_pkg::result_t           res;

    tes_note_mem #(
        .NOTE_DEPTH (NOTE_DEPTH)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    tes_ctrl #(
        .NOTE_DEPTH (NOTE_DEPTH)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_action   (s_tuser),
        .in_location (s_tdata[tes_pkg::LOC_W-1:0]),
        .in_word     (s_tdata[tes_pkg::LOC_W+tes_pkg::WORD_W-1:tes_pkg::LOC_W]),
        .mem_wr_en   (wr_en),
        .mem_wr_addr (wr_addr),
        .mem_wr_data (wr_data),
        .mem_rd_addr (rd_addr),
        .mem_rd_data (rd_data),
        .res_free    (res_free),
        .res_push    (res_push),
        .res         (res)
    );

    tes_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (res_push),
        .res      (res),
        .free     (res_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
